// ===== sv/onv_pkg.sv =====
// Package for the object name validator: prefix table and continuation range codes.
`default_nettype none
package onv_pkg;

   localparam int PREFIX_LEN = 26;
   localparam int PREFIX_W   = 5;

   typedef logic [2:0] range_type;

   localparam range_type RNG_ANY  = 3'd0;
   localparam range_type RNG_A0BF = 3'd1;
   localparam range_type RNG_809F = 3'd2;
   localparam range_type RNG_90BF = 3'd3;
   localparam range_type RNG_808F = 3'd4;

   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_DEL = 8'h7F;
   localparam logic [7:0] CHAR_SP  = 8'h20;

   function automatic logic [7:0] prefix_char(input logic [PREFIX_W-1:0] idx);
      logic [7:0] c;
      case (idx)
         5'd0:    c = ".";
         5'd1:    c = "w";
         5'd2:    c = "e";
         5'd3:    c = "l";
         5'd4:    c = "l";
         5'd5:    c = "-";
         5'd6:    c = "k";
         5'd7:    c = "n";
         5'd8:    c = "o";
         5'd9:    c = "w";
         5'd10:   c = "n";
         5'd11:   c = "/";
         5'd12:   c = "a";
         5'd13:   c = "c";
         5'd14:   c = "m";
         5'd15:   c = "e";
         5'd16:   c = "-";
         5'd17:   c = "c";
         5'd18:   c = "h";
         5'd19:   c = "a";
         5'd20:   c = "l";
         5'd21:   c = "l";
         5'd22:   c = "e";
         5'd23:   c = "n";
         5'd24:   c = "g";
         5'd25:   c = "e";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic cont_fits(input logic [7:0] b, input range_type rng);
      logic fits;
      case (rng)
         RNG_A0BF: fits = (b >= 8'hA0) && (b <= 8'hBF);
         RNG_809F: fits = (b >= 8'h80) && (b <= 8'h9F);
         RNG_90BF: fits = (b >= 8'h90) && (b <= 8'hBF);
         RNG_808F: fits = (b >= 8'h80) && (b <= 8'h8F);
         default:  fits = (b >= 8'h80) && (b <= 8'hBF);
      endcase
      return fits;
   endfunction

endpackage
`default_nettype wire

// ===== sv/object_name_validator_core.sv =====
// Object name validator: byte stream in, one verdict word per name out.
// A word is registered in the input register, its verdict in the result register on rsp_.
// Throughput: one word per cycle; the input register and the result register decouple
// the two channels, so a waiting verdict stalls the flow only at a word with last_byte.
// Reset: synchronous, active high; clears running name state and both valid flags.
`default_nettype none
module object_name_validator_core #(
   parameter int MAX_NAME_LENGTH = 1024
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_has_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_name_ok
);
   import onv_pkg::*;

   localparam int CNT_W = $clog2(MAX_NAME_LENGTH + 2);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_NAME_LENGTH + 1);
   localparam logic [PREFIX_W-1:0] PFX_END = PREFIX_W'(PREFIX_LEN);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_data_ff;
   logic                in_has_ff;
   logic                in_last_ff;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PREFIX_W-1:0] pfx_pos_ff, pfx_pos_in;
   logic                pfx_match_ff, pfx_match_in;
   logic                dots_ff, dots_in;
   logic [1:0]          pending_ff, pending_in;
   range_type           range_ff, range_in;
   logic                bad_ff, bad_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;

   logic                out_free;
   logic                process;
   logic                verdict;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign process   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || process;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_ready && req_valid) begin
         in_data_ff <= req_data_byte;
         in_has_ff  <= req_has_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_comb begin
      count_in     = count_ff;
      pfx_pos_in   = pfx_pos_ff;
      pfx_match_in = pfx_match_ff;
      dots_in      = dots_ff;
      pending_in   = pending_ff;
      range_in     = range_ff;
      bad_in       = bad_ff;
      if (in_has_ff) begin
         if (pfx_pos_ff != PFX_END) begin
            if (in_data_ff != prefix_char(pfx_pos_ff)) begin
               pfx_match_in = 1'b0;
            end
            pfx_pos_in = pfx_pos_ff + PREFIX_W'(1);
         end
         if (in_data_ff != CHAR_DOT) begin
            dots_in = 1'b0;
         end
         if (in_data_ff < CHAR_SP || in_data_ff == CHAR_DEL) begin
            bad_in = 1'b1;
         end
         if (pending_ff != 2'd0) begin
            if (cont_fits(in_data_ff, range_ff)) begin
               pending_in = pending_ff - 2'd1;
            end else begin
               bad_in     = 1'b1;
               pending_in = 2'd0;
            end
            range_in = RNG_ANY;
         end else if (in_data_ff <= 8'h7F) begin
            pending_in = 2'd0;
         end else if (in_data_ff >= 8'hC2 && in_data_ff <= 8'hDF) begin
            pending_in = 2'd1;
            range_in   = RNG_ANY;
         end else if (in_data_ff == 8'hE0) begin
            pending_in = 2'd2;
            range_in   = RNG_A0BF;
         end else if (in_data_ff == 8'hED) begin
            pending_in = 2'd2;
            range_in   = RNG_809F;
         end else if (in_data_ff >= 8'hE1 && in_data_ff <= 8'hEF) begin
            pending_in = 2'd2;
            range_in   = RNG_ANY;
         end else if (in_data_ff == 8'hF0) begin
            pending_in = 2'd3;
            range_in   = RNG_90BF;
         end else if (in_data_ff >= 8'hF1 && in_data_ff <= 8'hF3) begin
            pending_in = 2'd3;
            range_in   = RNG_ANY;
         end else if (in_data_ff == 8'hF4) begin
            pending_in = 2'd3;
            range_in   = RNG_808F;
         end else begin
            bad_in = 1'b1;
         end
         if (count_ff != CNT_LIMIT) begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      verdict = !bad_in
             && (count_in != '0)
             && (count_in != CNT_LIMIT)
             && !(dots_in && (count_in == CNT_W'(1) || count_in == CNT_W'(2)))
             && !(pfx_match_in && pfx_pos_in == PFX_END)
             && (pending_in == 2'd0);

      if (in_last_ff) begin
         count_in     = '0;
         pfx_pos_in   = '0;
         pfx_match_in = 1'b1;
         dots_in      = 1'b1;
         pending_in   = 2'd0;
         range_in     = RNG_ANY;
         bad_in       = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      if (process && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pfx_pos_ff   <= '0;
         pfx_match_ff <= 1'b1;
         dots_ff      <= 1'b1;
         pending_ff   <= 2'd0;
         range_ff     <= RNG_ANY;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (process) begin
            count_ff     <= count_in;
            pfx_pos_ff   <= pfx_pos_in;
            pfx_match_ff <= pfx_match_in;
            dots_ff      <= dots_in;
            pending_ff   <= pending_in;
            range_ff     <= range_in;
            bad_ff       <= bad_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_name_ok = rsp_ok_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      process && in_last_ff |=> count_ff == '0 && pending_ff == 2'd0 && !bad_ff)
      else $error("name state not cleared after last word");

   a_range_idle: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd0 |-> range_ff == RNG_ANY)
      else $error("continuation range set with nothing pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_LIMIT)
      else $error("byte count past saturation");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a blocked verdict");

endmodule
`default_nettype wire

// ===== tb/object_name_validator_core_test.sv =====
// Testbench for object_name_validator_core: directed table and random names checked by a predictor.
`timescale 1ns / 100ps
module object_name_validator_core_test;
   import onv_pkg::*;

   localparam int NAME_MAX    = 1024;
   localparam int ACME_LEN    = 26;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [0:ACME_LEN-1][7:0] ACME_PREFIX = ".well-known/acme-challenge";

   typedef enum logic [1:0] {SEE_MODEL, WANT_REJECT, WANT_ACCEPT} verdict_src_e;
   typedef enum logic [1:0] {MARK_NONE, MARK_HOLD, MARK_DRAIN} pace_mark_e;

   typedef struct packed {
      logic [7:0]   data;
      logic         has;
      logic         last;
      verdict_src_e verdict;
      pace_mark_e   mark;
   } name_word_t;

   localparam name_word_t STEER_ROWS [25] = '{
      {8'h00, 1'b0, 1'b1, WANT_REJECT, MARK_NONE},
      {8'h55, 1'b0, 1'b0, SEE_MODEL,   MARK_NONE},
      {8'h2E, 1'b1, 1'b1, WANT_REJECT, MARK_NONE},
      {8'h2E, 1'b1, 1'b0, SEE_MODEL,   MARK_NONE},
      {8'h2E, 1'b1, 1'b1, WANT_REJECT, MARK_NONE},
      {8'h61, 1'b1, 1'b1, WANT_ACCEPT, MARK_NONE},
      {8'h00, 1'b1, 1'b1, WANT_REJECT, MARK_NONE},
      {8'hFF, 1'b1, 1'b1, WANT_REJECT, MARK_NONE},
      {8'h7F, 1'b1, 1'b1, WANT_REJECT, MARK_NONE},
      {8'h0D, 1'b1, 1'b1, WANT_REJECT, MARK_NONE},
      {8'h0A, 1'b1, 1'b1, WANT_REJECT, MARK_NONE},
      {8'h20, 1'b1, 1'b0, SEE_MODEL,   MARK_NONE},
      {8'h7E, 1'b1, 1'b1, SEE_MODEL,   MARK_NONE},
      {8'hC2, 1'b1, 1'b0, SEE_MODEL,   MARK_NONE},
      {8'h80, 1'b1, 1'b1, SEE_MODEL,   MARK_NONE},
      {8'hE0, 1'b1, 1'b1, WANT_REJECT, MARK_NONE},
      {8'hED, 1'b1, 1'b0, SEE_MODEL,   MARK_NONE},
      {8'hA0, 1'b1, 1'b0, SEE_MODEL,   MARK_NONE},
      {8'h80, 1'b1, 1'b1, WANT_REJECT, MARK_NONE},
      {8'hF4, 1'b1, 1'b0, SEE_MODEL,   MARK_NONE},
      {8'h90, 1'b1, 1'b0, SEE_MODEL,   MARK_NONE},
      {8'h80, 1'b1, 1'b0, SEE_MODEL,   MARK_NONE},
      {8'h80, 1'b1, 1'b1, WANT_REJECT, MARK_NONE},
      {8'hC0, 1'b1, 1'b0, SEE_MODEL,   MARK_NONE},
      {8'h80, 1'b1, 1'b1, WANT_REJECT, MARK_NONE}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_has_byte = 1'b0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_name_ok;

   logic [10:0] cnt_seen = '0;
   logic        acme_hit = 1'b1;
   logic        dots_only = 1'b1;
   logic [1:0]  cont_owed = '0;
   range_type   cont_span = RNG_ANY;
   logic        saw_fault = 1'b0;

   name_word_t plan [$];
   logic [7:0] name_bytes [$];
   logic       pending_verdicts [$];
   int         planned = 0;
   int         idle_pct = 0;
   logic       hold_rsp = 1'b0;
   int         mismatches = 0;
   int         quiet_cycles = 0;
   logic       want_ok;

   object_name_validator_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_has_byte  (req_has_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_name_ok   (rsp_name_ok)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] pick(input int lo, input int hi);
      logic [7:0] v;
      v = 8'($urandom_range(hi, lo));
      return v;
   endfunction

   function automatic name_word_t word_of(input logic [7:0] d, input logic h, input logic l);
      name_word_t w;
      w.data    = d;
      w.has     = h;
      w.last    = l;
      w.verdict = SEE_MODEL;
      w.mark    = MARK_NONE;
      return w;
   endfunction

   task automatic judge_word(input logic [7:0] b, input logic has, input logic last,
                             output logic ok);
      logic fits;
      ok = 1'b0;
      if (has) begin
         if (cnt_seen < ACME_LEN) begin
            if (b != ACME_PREFIX[cnt_seen]) acme_hit = 1'b0;
         end
         if (b != CHAR_DOT) dots_only = 1'b0;
         if (b < 8'h20 || b == 8'h7F) saw_fault = 1'b1;
         if (cont_owed != 0) begin
            case (cont_span)
               RNG_A0BF: fits = b >= 8'hA0 && b <= 8'hBF;
               RNG_809F: fits = b >= 8'h80 && b <= 8'h9F;
               RNG_90BF: fits = b >= 8'h90 && b <= 8'hBF;
               RNG_808F: fits = b >= 8'h80 && b <= 8'h8F;
               default:  fits = b >= 8'h80 && b <= 8'hBF;
            endcase
            if (fits) begin
               cont_owed = cont_owed - 2'd1;
            end else begin
               saw_fault = 1'b1;
               cont_owed = 2'd0;
            end
            cont_span = RNG_ANY;
         end else if (b[7]) begin
            if (b >= 8'hC2 && b <= 8'hDF) begin
               cont_owed = 2'd1;
               cont_span = RNG_ANY;
            end else if (b == 8'hE0) begin
               cont_owed = 2'd2;
               cont_span = RNG_A0BF;
            end else if (b == 8'hED) begin
               cont_owed = 2'd2;
               cont_span = RNG_809F;
            end else if (b >= 8'hE1 && b <= 8'hEF) begin
               cont_owed = 2'd2;
               cont_span = RNG_ANY;
            end else if (b == 8'hF0) begin
               cont_owed = 2'd3;
               cont_span = RNG_90BF;
            end else if (b >= 8'hF1 && b <= 8'hF3) begin
               cont_owed = 2'd3;
               cont_span = RNG_ANY;
            end else if (b == 8'hF4) begin
               cont_owed = 2'd3;
               cont_span = RNG_808F;
            end else begin
               saw_fault = 1'b1;
            end
         end
         if (cnt_seen <= NAME_MAX) cnt_seen = cnt_seen + 11'd1;
      end
      if (last) begin
         ok = !saw_fault && cnt_seen != 0 && cnt_seen <= NAME_MAX && cont_owed == 0
              && !(dots_only && (cnt_seen == 1 || cnt_seen == 2))
              && !(acme_hit && cnt_seen >= ACME_LEN);
         cnt_seen  = '0;
         acme_hit  = 1'b1;
         dots_only = 1'b1;
         cont_owed = '0;
         cont_span = RNG_ANY;
         saw_fault = 1'b0;
      end
   endtask

   task automatic add_valid_char();
      logic [7:0] lead;
      case ($urandom_range(0, 5))
         3: begin
            name_bytes.push_back(pick(8'hC2, 8'hDF));
            name_bytes.push_back(pick(8'h80, 8'hBF));
         end
         4: begin
            lead = pick(8'hE0, 8'hEF);
            name_bytes.push_back(lead);
            if (lead == 8'hE0)      name_bytes.push_back(pick(8'hA0, 8'hBF));
            else if (lead == 8'hED) name_bytes.push_back(pick(8'h80, 8'h9F));
            else                    name_bytes.push_back(pick(8'h80, 8'hBF));
            name_bytes.push_back(pick(8'h80, 8'hBF));
         end
         5: begin
            lead = pick(8'hF0, 8'hF4);
            name_bytes.push_back(lead);
            if (lead == 8'hF0)      name_bytes.push_back(pick(8'h90, 8'hBF));
            else if (lead == 8'hF4) name_bytes.push_back(pick(8'h80, 8'h8F));
            else                    name_bytes.push_back(pick(8'h80, 8'hBF));
            name_bytes.push_back(pick(8'h80, 8'hBF));
            name_bytes.push_back(pick(8'h80, 8'hBF));
         end
         default: name_bytes.push_back(pick(8'h20, 8'h7E));
      endcase
   endtask

   task automatic emit_name();
      logic end_empty;
      end_empty = name_bytes.size() == 0 || $urandom_range(0, 3) == 0;
      foreach (name_bytes[i]) begin
         if ($urandom_range(0, 15) == 0) plan.push_back(word_of(pick(0, 255), 1'b0, 1'b0));
         plan.push_back(word_of(name_bytes[i], 1'b1,
                                !end_empty && i == name_bytes.size() - 1));
         planned++;
      end
      if (end_empty) begin
         plan.push_back(word_of(pick(0, 255), 1'b0, 1'b1));
         planned++;
      end
      name_bytes.delete();
   endtask

   task automatic add_random_name();
      int         r;
      int         n;
      int         j;
      logic [7:0] lead;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         // empty name
      end else if (r < 55) begin
         n = $urandom_range(1, 8);
         repeat (n) add_valid_char();
      end else if (r < 65) begin
         n = $urandom_range(ACME_LEN - 2, ACME_LEN);
         for (int i = 0; i < n; i++) name_bytes.push_back(ACME_PREFIX[i]);
         if ($urandom_range(0, 2) == 0) begin
            j = $urandom_range(0, n - 1);
            name_bytes[j] = name_bytes[j] ^ 8'h20;
         end
         repeat ($urandom_range(0, 3)) add_valid_char();
      end else if (r < 72) begin
         repeat ($urandom_range(1, 3)) name_bytes.push_back(CHAR_DOT);
         if ($urandom_range(0, 3) == 0) add_valid_char();
      end else if (r < 87) begin
         repeat ($urandom_range(0, 4)) add_valid_char();
         case ($urandom_range(0, 4))
            0: begin
               lead = pick(8'hC2, 8'hF4);
               name_bytes.push_back(lead);
               if (lead >= 8'hE0 && $urandom_range(0, 1)) name_bytes.push_back(pick(8'h80, 8'h8F));
            end
            1: name_bytes.push_back($urandom_range(0, 4) == 0 ? CHAR_DEL : pick(8'h00, 8'h1F));
            2: begin
               lead = pick(8'hC2, 8'hF4);
               name_bytes.push_back(lead);
               if (lead == 8'hE0)      name_bytes.push_back(pick(8'h80, 8'h9F));
               else if (lead == 8'hED) name_bytes.push_back(pick(8'hA0, 8'hBF));
               else if (lead == 8'hF0) name_bytes.push_back(pick(8'h80, 8'h8F));
               else if (lead == 8'hF4) name_bytes.push_back(pick(8'h90, 8'hBF));
               else if ($urandom_range(0, 1)) name_bytes.push_back(pick(8'h00, 8'h7F));
               else name_bytes.push_back(pick(8'hC0, 8'hFF));
            end
            3: name_bytes.push_back($urandom_range(0, 2) == 0 ? pick(8'hC0, 8'hC1)
                                                               : pick(8'hF5, 8'hFF));
            default: name_bytes.push_back(pick(8'h80, 8'hBF));
         endcase
         repeat ($urandom_range(0, 2)) add_valid_char();
      end else begin
         repeat ($urandom_range(1, 8)) name_bytes.push_back(pick(0, 255));
      end
      emit_name();
   endtask

   initial begin
      name_word_t w;
      int         drain_at;
      int         base;
      int         long_len [3];
      logic       ok;

      foreach (STEER_ROWS[i]) plan.push_back(STEER_ROWS[i]);
      while (planned < 200) add_random_name();
      for (int i = 0; i < 24; i++) begin
         w = word_of(pick(8'h61, 8'h7A), 1'b1, 1'b1);
         if (i == 0) w.mark = MARK_HOLD;
         plan.push_back(w);
         planned++;
      end
      drain_at = plan.size();
      long_len = '{NAME_MAX, NAME_MAX + 1, NAME_MAX + 76};
      foreach (long_len[i]) begin
         repeat (long_len[i]) name_bytes.push_back(pick(8'h21, 8'h7E));
         emit_name();
      end
      plan[drain_at].mark = MARK_DRAIN;
      base = planned;
      while (planned < base + 200) add_random_name();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         w = plan[k];
         if (k % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: idle_pct = 0;
               1: idle_pct = 5;
               2: idle_pct = 20;
               default: idle_pct = 45;
            endcase
         end
         if (k + 60 >= plan.size()) idle_pct = 0;
         if (w.mark == MARK_DRAIN) begin
            req_valid <= 1'b0;
            while (pending_verdicts.size() != 0) @(posedge clock);
            @(negedge clock);
         end
         if (w.mark == MARK_HOLD) hold_rsp = 1'b1;
         if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         req_valid     <= 1'b1;
         req_data_byte <= w.data;
         req_has_byte  <= w.has;
         req_last_byte <= w.last;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         judge_word(w.data, w.has, w.last, ok);
         if (w.last) begin
            if (w.verdict == SEE_MODEL) pending_verdicts.push_back(ok);
            else pending_verdicts.push_back(w.verdict == WANT_ACCEPT);
         end
         @(negedge clock);
      end
      req_valid <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS object_name_validator_core");
      end else begin
         $display("FAIL object_name_validator_core");
      end
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches < 50)
               $display("%0t: verdict with none expected, name_ok %0b", $time, rsp_name_ok);
         end else begin
            want_ok = pending_verdicts.pop_front();
            if (rsp_name_ok !== want_ok) begin
               mismatches++;
               if (mismatches < 50)
                  $display("%0t: name_ok expected %0b, got %0b", $time, want_ok, rsp_name_ok);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAIL object_name_validator_core");
         $finish;
      end
   end

endmodule
